/* sv/slab_slot_allocator_with_expiry_unit_defines.svh */
// Assertion macros for the slab slot allocator.
// Used by the top level; needs clk and rst_n in scope.
`ifndef SLAB_SLOT_ALLOCATOR_WITH_EXPIRY_UNIT_DEFINES_SVH
`define SLAB_SLOT_ALLOCATOR_WITH_EXPIRY_UNIT_DEFINES_SVH

// same-cycle implication
`define SSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ssa_pkg.sv */
// Shared types and codes for the slab slot allocator.
// No dependencies.
package ssa_pkg;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

  localparam int CMP_SLOT_W = 10;
  localparam int CMP_TIME_W = 32;

  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_SLOT_BYTES = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  slot_index;
    logic [31:0] expiry_time;
    logic [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  granted_slot;
    logic [21:0] byte_offset;
    logic [6:0]  free_total;
    logic [6:0]  allocated_total;
    logic [6:0]  swept_total;
  } out_item_t;

  typedef struct packed {
    logic                  sweep;
    logic                  found;
    logic [CMP_SLOT_W-1:0] slot;
    logic [CMP_SLOT_W-1:0] target;
    logic [CMP_TIME_W-1:0] expiry;
    logic [CMP_TIME_W-1:0] now;
  } cmp_req_t;

endpackage

/* sv/ssa_cmp.sv */
// Shared compare unit: decides whether a list entry is removed.
// Depends on ssa_pkg.
module ssa_cmp import ssa_pkg::*; (
  input  cmp_req_t req,
  output logic     hit
);

  always_comb begin
    if (req.sweep) begin
      hit = (req.expiry != '0) && (req.expiry <= req.now);
    end else begin
      hit = !req.found && (req.slot == req.target);
    end
  end

endmodule

/* sv/slab_slot_allocator_with_expiry_unit.sv */
// Slab slot allocator with expiry: top level, sequencer and memories.
// Depends on ssa_pkg, ssa_cmp and the assertion macro header.
//
// Usage:
//   in_* channel (valid/stall) carries one request item: allocate, free, sweep.
//   out_* channel (valid/stall) returns one result item per request.
//   APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
//   slot_count at 0x0 and slot_bytes at 0x4; write only while idle.
//   Writing slot_count rebuilds the slab: all allocations are dropped.
// Steps:
//   allocate: stack read, grant write, offset multiply, result.
//   free/sweep: one pass over the allocated list of length L (at most
//   MAX_SLOTS); each entry takes order read, expiry read, compare/compact
//   through the single shared compare unit. Empty list: straight to result.
//   One item is in work at a time; in_stall is high while busy.
// Reset: slot_count 64, slot_bytes 64, slots 0..N-1 free, nothing allocated.
//   No clearing pass; stack entries never written read as their own index
//   via a low-water mark.
// Stall: a finished result sits in the output register; the next item is
//   accepted meanwhile and holds in its final step until the register frees.
module slab_slot_allocator_with_expiry_unit import ssa_pkg::*; #(
  parameter int MAX_SLOTS = 64,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "slab_slot_allocator_with_expiry_unit_defines.svh"

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int TW    = (TIME_BITS < 32) ? TIME_BITS : 32;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_POP   = 8'b0000_0010,
    S_GRANT = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_RD    = 8'b0001_0000,
    S_EXP   = 8'b0010_0000,
    S_DEC   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // memories
  logic [IDX_W-1:0] stk_mem [MAX_SLOTS];
  logic [IDX_W-1:0] ord_mem [MAX_SLOTS];
  logic [TW-1:0]    exp_mem [MAX_SLOTS];

  state_t           state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [5:0]       idx_r, idx_nxt;
  logic [TW-1:0]    exp_r, exp_nxt;
  logic [TW-1:0]    now_r, now_nxt;
  logic [6:0]       slot_count_r, slot_count_nxt;
  logic [15:0]      slot_bytes_r, slot_bytes_nxt;
  logic [CNT_W-1:0] free_depth_r, free_depth_nxt;
  logic [CNT_W-1:0] alloc_depth_r, alloc_depth_nxt;
  logic [CNT_W-1:0] min_r, min_nxt;         // low-water mark of the stack
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             use_init_r, use_init_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [21:0]      offset_r, offset_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] wr_r, wr_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] swept_r, swept_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic [IDX_W-1:0] stk_q, ord_q;
  logic [TW-1:0]    exp_q;
  logic [IDX_W-1:0] stk_raddr;
  logic             stk_we, ord_we, exp_we;
  logic [IDX_W-1:0] stk_waddr, stk_wdata, ord_waddr, ord_wdata, exp_waddr;
  logic [TW-1:0]    exp_wdata;

  logic             in_acc, cfg_wr;
  logic [CNT_W-1:0] cfg_n;
  logic [IDX_W-1:0] grant_slot;
  logic [37:0]      prod;
  cmp_req_t         cmp_req;
  logic             hit;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign prdata = (paddr[2] == REG_SLOT_BYTES) ? {16'd0, slot_bytes_r}
                                               : {25'd0, slot_count_r};

  // saturated slot count for a rebuild
  assign cfg_n = (32'(pwdata[6:0]) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS)
                                                : CNT_W'(pwdata[6:0]);

  assign grant_slot = use_init_r ? pos_r : stk_q;
  assign prod = 38'(slot_r) * 38'(slot_bytes_r);

  assign cmp_req.sweep  = (op_r == OP_SWEEP);
  assign cmp_req.found  = found_r;
  assign cmp_req.slot   = CMP_SLOT_W'(ord_q);
  assign cmp_req.target = CMP_SLOT_W'(idx_r);
  assign cmp_req.expiry = CMP_TIME_W'(exp_q);
  assign cmp_req.now    = CMP_TIME_W'(now_r);

  ssa_cmp u_cmp (
    .req (cmp_req),
    .hit (hit)
  );

  assign stk_raddr = IDX_W'(free_depth_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    stk_q <= stk_mem[stk_raddr];
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk) begin
    ord_q <= ord_mem[rd_r[IDX_W-1:0]];
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
  end

  always_ff @(posedge clk) begin
    exp_q <= exp_mem[ord_q];
    if (exp_we) begin
      exp_mem[exp_waddr] <= exp_wdata;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    idx_nxt         = idx_r;
    exp_nxt         = exp_r;
    now_nxt         = now_r;
    slot_count_nxt  = slot_count_r;
    slot_bytes_nxt  = slot_bytes_r;
    free_depth_nxt  = free_depth_r;
    alloc_depth_nxt = alloc_depth_r;
    min_nxt         = min_r;
    pos_nxt         = pos_r;
    use_init_nxt    = use_init_r;
    slot_nxt        = slot_r;
    offset_nxt      = offset_r;
    status_nxt      = status_r;
    rd_nxt          = rd_r;
    wr_nxt          = wr_r;
    len_nxt         = len_r;
    swept_nxt       = swept_r;
    found_nxt       = found_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_item_nxt    = out_item_r;
    stk_we    = 1'b0;
    stk_waddr = free_depth_r[IDX_W-1:0];
    stk_wdata = ord_q;
    ord_we    = 1'b0;
    ord_waddr = wr_r[IDX_W-1:0];
    ord_wdata = ord_q;
    exp_we    = 1'b0;
    exp_waddr = grant_slot;
    exp_wdata = exp_r;

    if (cfg_wr) begin
      if (paddr[2] == REG_SLOT_COUNT) begin
        slot_count_nxt  = pwdata[6:0];
        free_depth_nxt  = cfg_n;
        alloc_depth_nxt = '0;
        min_nxt         = cfg_n;
      end else begin
        slot_bytes_nxt = pwdata[15:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_item.operation;
          idx_nxt    = in_item.slot_index;
          exp_nxt    = in_item.expiry_time[TW-1:0];
          now_nxt    = in_item.current_time[TW-1:0];
          slot_nxt   = '0;
          offset_nxt = '0;
          status_nxt = ST_OK;
          rd_nxt     = '0;
          wr_nxt     = '0;
          swept_nxt  = '0;
          found_nxt  = 1'b0;
          len_nxt    = alloc_depth_r;
          case (in_item.operation)
            OP_ALLOC: begin
              if (free_depth_r == '0 || 32'(alloc_depth_r) >= MAX_SLOTS) begin
                status_nxt = ST_NO_FREE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_POP;
              end
            end
            OP_FREE, OP_SWEEP: begin
              state_nxt = (alloc_depth_r == '0) ? S_DONE : S_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_POP: begin
        // stk_q is loaded at this edge from position free_depth-1
        pos_nxt        = stk_raddr;
        use_init_nxt   = (free_depth_r - CNT_W'(1)) < min_r;
        if ((free_depth_r - CNT_W'(1)) < min_r) begin
          min_nxt = free_depth_r - CNT_W'(1);
        end
        free_depth_nxt = free_depth_r - CNT_W'(1);
        state_nxt      = S_GRANT;
      end
      S_GRANT: begin
        ord_we          = 1'b1;
        ord_waddr       = alloc_depth_r[IDX_W-1:0];
        ord_wdata       = grant_slot;
        exp_we          = 1'b1;
        alloc_depth_nxt = alloc_depth_r + CNT_W'(1);
        slot_nxt        = grant_slot;
        state_nxt       = S_MUL;
      end
      S_MUL: begin
        offset_nxt = prod[21:0];
        state_nxt  = S_DONE;
      end
      S_RD: begin
        state_nxt = S_EXP;
      end
      S_EXP: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (hit) begin
          if (32'(free_depth_r) < MAX_SLOTS) begin
            stk_we         = 1'b1;
            free_depth_nxt = free_depth_r + CNT_W'(1);
          end
          found_nxt = 1'b1;
          swept_nxt = swept_r + CNT_W'(1);
        end else begin
          ord_we = (wr_r != rd_r);
          wr_nxt = wr_r + CNT_W'(1);
        end
        rd_nxt = rd_r + CNT_W'(1);
        if (rd_r + CNT_W'(1) == len_r) begin
          alloc_depth_nxt = hit ? wr_r : wr_r + CNT_W'(1);
          state_nxt       = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt                = 1'b1;
          out_item_nxt.granted_slot    = 6'(slot_r);
          out_item_nxt.byte_offset     = offset_r;
          out_item_nxt.free_total      = 7'(free_depth_r);
          out_item_nxt.allocated_total = 7'(alloc_depth_r);
          out_item_nxt.swept_total     = (op_r == OP_SWEEP) ? 7'(swept_r) : 7'd0;
          if (op_r == OP_FREE) begin
            out_item_nxt.status = found_r ? ST_OK : ST_NOT_ALLOC;
          end else begin
            out_item_nxt.status = status_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_count_r  <= 7'd64;
      slot_bytes_r  <= 16'd64;
      free_depth_r  <= (MAX_SLOTS < 64) ? CNT_W'(MAX_SLOTS) : CNT_W'(64);
      min_r         <= (MAX_SLOTS < 64) ? CNT_W'(MAX_SLOTS) : CNT_W'(64);
      alloc_depth_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      slot_count_r  <= slot_count_nxt;
      slot_bytes_r  <= slot_bytes_nxt;
      free_depth_r  <= free_depth_nxt;
      min_r         <= min_nxt;
      alloc_depth_r <= alloc_depth_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    exp_r      <= exp_nxt;
    now_r      <= now_nxt;
    pos_r      <= pos_nxt;
    use_init_r <= use_init_nxt;
    slot_r     <= slot_nxt;
    offset_r   <= offset_nxt;
    status_r   <= status_nxt;
    rd_r       <= rd_nxt;
    wr_r       <= wr_nxt;
    len_r      <= len_nxt;
    swept_r    <= swept_nxt;
    found_r    <= found_nxt;
    out_item_r <= out_item_nxt;
  end

  // free and allocated slots always add up to the slab size when idle
  `SSA_ASSERT_IMP(a_conserve, state_r == S_IDLE, 32'(free_depth_r) + 32'(alloc_depth_r) == ((32'(slot_count_r) > MAX_SLOTS) ? MAX_SLOTS : 32'(slot_count_r)), "slot totals lost")
  // an accepted item makes the block busy
  `SSA_ASSERT_NXT(a_busy, in_acc, in_stall, "not busy after accept")
  // stack never overflows
  `SSA_ASSERT_IMP(a_depth, 1'b1, 32'(free_depth_r) <= MAX_SLOTS, "free stack overflow")

endmodule

/* tb/slab_slot_allocator_with_expiry_unit_test.sv */
// Testbench for the slab slot allocator: a directed table, then random request items
// checked against an in-bench model of the slab. Depends on ssa_pkg and the top level.
module slab_slot_allocator_with_expiry_unit_test import ssa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 has no name in the package: it is a no-op that only reports totals.
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int SLOTS = 64;
  localparam int PHASE_ITEMS = 225;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  slab_slot_allocator_with_expiry_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Slab model: free stack, allocation-ordered list and per-slot expiry.
  // ---------------------------------------------------------------------------
  logic [15:0] slot_size;
  logic [5:0]  free_stack [SLOTS];
  int          free_depth;
  logic [5:0]  alloc_list [SLOTS];
  int          alloc_depth;
  logic [31:0] slot_expiry [SLOTS];

  out_item_t   pending_results [$];
  int          mismatch_count = 0;
  logic [31:0] clock_now = 32'd1000;   // running time base for random expiries

  // Writing slot_count drops everything; counts above the slab size saturate.
  task automatic rebuild_slab(input int count);
    for (int i = 0; i < SLOTS; i++) free_stack[i] = 6'(i);
    free_depth  = (count > SLOTS) ? SLOTS : count;
    alloc_depth = 0;
  endtask

  // Removes list position pos, keeping the order of the rest.
  function automatic void drop_position(input int pos);
    for (int k = pos; k + 1 < alloc_depth; k++) alloc_list[k] = alloc_list[k + 1];
    alloc_depth--;
  endfunction

  function automatic void push_free(input logic [5:0] slot);
    if (free_depth < SLOTS) begin
      free_stack[free_depth] = slot;
      free_depth++;
    end
  endfunction

  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t   res;
    logic [5:0]  slot;
    logic [31:0] prod;
    int          k;
    bit          found;
    res = '0;
    res.status = ST_OK;
    case (req.operation)
      OP_ALLOC: begin
        if (free_depth == 0 || alloc_depth >= SLOTS) begin
          res.status = ST_NO_FREE;
        end else begin
          free_depth--;
          slot = free_stack[free_depth];
          alloc_list[alloc_depth] = slot;
          alloc_depth++;
          slot_expiry[slot] = req.expiry_time;
          prod = 32'(slot) * 32'(slot_size);
          res.granted_slot = slot;
          res.byte_offset  = prod[21:0];
        end
      end
      OP_FREE: begin
        found = 1'b0;
        for (k = 0; k < alloc_depth && !found; k++) begin
          if (alloc_list[k] == req.slot_index) begin
            drop_position(k);
            push_free(req.slot_index);
            found = 1'b1;
          end
        end
        if (!found) res.status = ST_NOT_ALLOC;
      end
      OP_SWEEP: begin
        k = 0;
        while (k < alloc_depth) begin
          slot = alloc_list[k];
          if (slot_expiry[slot] != 0 && slot_expiry[slot] <= req.current_time) begin
            drop_position(k);
            push_free(slot);
            res.swept_total++;
          end else begin
            k++;
          end
        end
      end
      default: ;
    endcase
    res.free_total      = 7'(free_depth);
    res.allocated_total = 7'(alloc_depth);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern switches at random among four modes so that
  // stalls land on every step of the block's walk, with stall-free stretches.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_cycles = 0;
  always @(negedge clk) begin
    stall_cycles <= stall_cycles + 1;
    if (stall_cycles % 300 == 299) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= (stall_cycles % 7 < 3);
    endcase
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item %h at %0t", out_item, $realtime);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status ||
            out_item.granted_slot !== want.granted_slot ||
            out_item.byte_offset !== want.byte_offset ||
            out_item.free_total !== want.free_total ||
            out_item.allocated_total !== want.allocated_total ||
            out_item.swept_total !== want.swept_total) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: status %0d/%0d slot %0d/%0d offset %0d/%0d",
                     $realtime, want.status, out_item.status, want.granted_slot,
                     out_item.granted_slot, want.byte_offset, out_item.byte_offset,
                     "\n  free %0d/%0d allocated %0d/%0d swept %0d/%0d (want/got)",
                     want.free_total, out_item.free_total, want.allocated_total,
                     out_item.allocated_total, want.swept_total, out_item.swept_total);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------
  // Holds the item until accepted; valid is only lowered by the caller on a gap.
  task automatic send_item(input in_item_t req, input bit typed, input out_item_t typed_res);
    out_item_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    res = apply_request(req);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Pause the sender until the block has returned everything.
  task automatic drain;
    idle_cycles(1);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // APB write: setup then access, register taken at the edge with pready high.
  task automatic write_reg(input logic reg_index, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {reg_index, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_index == REG_SLOT_COUNT) rebuild_slab(int'(value[6:0]));
    else slot_size = value[15:0];
  endtask

  function automatic in_item_t random_request;
    in_item_t req;
    int pick;
    req = '0;
    req.slot_index   = 6'($urandom);
    req.expiry_time  = $urandom;
    req.current_time = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      req.operation = OP_ALLOC;
      pick = $urandom_range(0, 19);
      if (pick < 2) req.expiry_time = '0;
      else if (pick < 18) req.expiry_time = clock_now + $urandom_range(1, 300);
    end else if (pick < 75) begin
      // mostly free something that is really allocated
      req.operation = OP_FREE;
      if (alloc_depth > 0 && $urandom_range(0, 4) != 0)
        req.slot_index = alloc_list[$urandom_range(0, alloc_depth - 1)];
    end else if (pick < 95) begin
      req.operation = OP_SWEEP;
      clock_now += $urandom_range(0, 80);
      pick = $urandom_range(0, 19);
      if (pick < 16) req.current_time = clock_now;
      else if (pick < 18) req.current_time = '1;
    end else begin
      req.operation = OP_NOP;
    end
    return req;
  endfunction

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t res;
  } plan_row_t;

  plan_row_t plan [$];

  task automatic add_row(input logic [1:0] op, input logic [5:0] idx,
                         input logic [31:0] exp_t, input logic [31:0] now_t,
                         input bit typed, input out_item_t res);
    plan_row_t row;
    row.req   = '{operation: op, slot_index: idx, expiry_time: exp_t, current_time: now_t};
    row.typed = typed;
    row.res   = res;
    plan.insert(plan.size(), row);
  endtask

  task automatic run_phase(input int items, input bit gaps);
    int burst;
    int sent;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < items; b++) begin
        send_item(random_request(), 1'b0, '0);
        sent++;
        if (sent == items / 2 && $urandom_range(0, 1)) drain();
      end
      if (gaps) idle_cycles($urandom_range(0, 12));
    end
  endtask

  initial begin
    out_item_t none;
    none = '0;
    rebuild_slab(64);
    slot_size = 16'd64;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Expected results are typed in where they follow directly
    // from the reset state (64 slots of 64 bytes, highest slot granted first).
    add_row(OP_ALLOC, 6'd0, 32'd0, 32'd0, 1, '{ST_OK, 6'd63, 22'd4032, 7'd63, 7'd1, 7'd0});
    add_row(OP_ALLOC, 6'd0, 32'd5, 32'd0, 1, '{ST_OK, 6'd62, 22'd3968, 7'd62, 7'd2, 7'd0});
    add_row(OP_ALLOC, 6'd0, '1, 32'd0, 1, '{ST_OK, 6'd61, 22'd3904, 7'd61, 7'd3, 7'd0});
    add_row(OP_FREE, 6'd0, '0, '0, 1, '{ST_NOT_ALLOC, 6'd0, 22'd0, 7'd61, 7'd3, 7'd0});
    add_row(OP_SWEEP, 6'd0, '0, 32'd4, 1, '{ST_OK, 6'd0, 22'd0, 7'd61, 7'd3, 7'd0});
    add_row(OP_SWEEP, 6'd0, '0, 32'd5, 1, '{ST_OK, 6'd0, 22'd0, 7'd62, 7'd2, 7'd1});
    add_row(OP_NOP, '1, '1, '1, 1, '{ST_OK, 6'd0, 22'd0, 7'd62, 7'd2, 7'd0});
    add_row(OP_FREE, 6'd63, '0, '0, 1, '{ST_OK, 6'd0, 22'd0, 7'd63, 7'd1, 7'd0});
    add_row(OP_SWEEP, 6'd0, '0, '1, 1, '{ST_OK, 6'd0, 22'd0, 7'd64, 7'd0, 7'd1});
    add_row(OP_SWEEP, 6'd0, '0, '1, 1, '{ST_OK, 6'd0, 22'd0, 7'd64, 7'd0, 7'd0});
    add_row(OP_FREE, 6'd61, '0, '0, 1, '{ST_NOT_ALLOC, 6'd0, 22'd0, 7'd64, 7'd0, 7'd0});
    // model-checked rows: mixed expiries, sweep at zero time, frees in odd order
    add_row(OP_ALLOC, '0, 32'd10, '0, 0, none);
    add_row(OP_ALLOC, '1, 32'd0, '1, 0, none);
    add_row(OP_ALLOC, '0, 32'd10, '0, 0, none);
    add_row(OP_ALLOC, '0, 32'h8000_0000, '0, 0, none);
    add_row(OP_SWEEP, '0, '0, 32'd0, 0, none);
    add_row(OP_FREE, 6'd62, '0, '0, 0, none);
    add_row(OP_SWEEP, '0, '0, 32'd10, 0, none);
    add_row(OP_SWEEP, '0, '0, 32'h7FFF_FFFF, 0, none);
    add_row(OP_SWEEP, '0, '0, 32'h8000_0000, 0, none);
    add_row(OP_FREE, 6'd61, '0, '0, 0, none);
    add_row(OP_FREE, 6'd61, '0, '0, 0, none);
    foreach (plan[i]) send_item(plan[i].req, plan[i].typed, plan[i].res);
    drain();

    // Random phases, each with its own slab geometry; registers change only
    // once the block has returned every result.
    run_phase(PHASE_ITEMS, 1);
    drain();
    write_reg(REG_SLOT_COUNT, 32'd1);
    write_reg(REG_SLOT_BYTES, 32'd65535);
    run_phase(PHASE_ITEMS, 0);
    drain();
    write_reg(REG_SLOT_COUNT, 32'd0);       // empty slab: every allocate fails
    write_reg(REG_SLOT_BYTES, 32'd1);
    run_phase(60, 1);
    drain();
    write_reg(REG_SLOT_COUNT, 32'd127);     // saturates to a full slab
    write_reg(REG_SLOT_BYTES, 32'hFFFF_03E8);
    run_phase(PHASE_ITEMS, 1);
    drain();
    write_reg(REG_SLOT_BYTES, $urandom);
    write_reg(REG_SLOT_COUNT, $urandom_range(2, 63));
    run_phase(PHASE_ITEMS, 1);
    drain();
    write_reg(REG_SLOT_COUNT, 32'd64);
    write_reg(REG_SLOT_BYTES, 32'd65535);
    run_phase(PHASE_ITEMS + 150, 1);
    drain();

    repeat (250) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/ssa_pkg.sv
sv/ssa_cmp.sv
sv/slab_slot_allocator_with_expiry_unit.sv
tb/slab_slot_allocator_with_expiry_unit_test.sv
